### sv/plosm_pkg.sv
package plosm_pkg;
  localparam int ENTRIES_DEF  = 16;
  localparam int PIN_BITS_DEF = 8;

  typedef enum logic [1:0] {
    OP_OPEN   = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_LOCK   = 2'd2,
    OP_UNLOCK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PINNED = 2'd1,
    ST_FAIL   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_EVOUT,
    S_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic exec;     // apply the operation
    logic walk;     // examine one recency position
    logic fin;      // build final result
    logic out_take; // result accepted downstream
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic walk_hit;
  } stat_t;
endpackage

### sv/plosm_ctrl.sv
module plosm_ctrl
  import plosm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = st.need_walk ? S_WALK : S_FINAL;
      S_WALK: begin
        if (st.walk_hit)       state_nxt = S_EVOUT;
        else if (st.walk_done) state_nxt = S_FINAL;
      end
      S_EVOUT: if (out_ready) state_nxt = S_WALK;
      S_FINAL: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_WALK: begin
        cmd.walk = 1'b1;
        cmd.fin  = st.walk_done && !st.walk_hit;
      end
      S_EVOUT: begin
        out_valid    = 1'b1;
        cmd.out_take = out_ready;
      end
      S_FINAL: begin
        out_valid    = 1'b1;
        cmd.out_take = out_ready;
      end
      default: ;
    endcase
  end
endmodule

### sv/plosm_dp.sv
module plosm_dp
  import plosm_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output stat_t      st,
  input  logic [1:0] in_op,
  input  logic [3:0] in_entry,
  input  logic       in_new_name,
  input  logic       in_open_ok,
  input  logic       cfg_valid,
  input  logic [4:0] cfg_max_open,
  output logic [1:0] out_status,
  output logic       out_evicted_valid,
  output logic [3:0] out_evicted_entry,
  output logic       out_now_open,
  output logic [7:0] out_pin_count,
  output logic       out_is_last
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  logic [ENTRIES-1:0]  open_r, named_r;
  logic [PIN_BITS-1:0] pins_r [ENTRIES];
  logic [IW-1:0]       ord_r  [ENTRIES];
  logic [CW-1:0]       cnt_r;
  logic [4:0]          maxo_r;
  logic [1:0]          op_r;
  logic [IW-1:0]       e_r;
  logic                nn_r, ok_r;
  logic [CW-1:0]       pos_r;
  logic [1:0]          stat_r;
  logic [IW-1:0]       ev_r;
  logic                evv_r, last_r, now_cur;
  logic [PIN_BITS-1:0] pc_cur;

  // position of addressed entry in the order
  logic [IW-1:0] fpos;
  always_comb begin
    fpos = '0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (CW'(i) < cnt_r && ord_r[i] == e_r) fpos = IW'(i);
  end

  logic [CW-1:0]       posm1;
  logic [IW-1:0]       wentry;
  logic                over;
  assign posm1  = pos_r - 1'b1;
  assign wentry = ord_r[posm1[IW-1:0]];
  assign over   = {{(CW < 6 ? 6 - CW : 0){1'b0}}, cnt_r} > 6'(maxo_r);
  assign st.walk_done = !over || pos_r == '0;
  assign st.walk_hit  = !st.walk_done && pins_r[wentry] == '0;

  logic pinned, isopen, do_open, do_close, do_front, walk_nxt;
  logic [1:0] sx;
  always_comb begin
    pinned   = pins_r[e_r] != '0;
    isopen   = open_r[e_r];
    do_open  = 1'b0; do_close = 1'b0; do_front = 1'b0; walk_nxt = 1'b0;
    sx       = ST_OK;
    case (op_t'(op_r))
      OP_OPEN: begin
        if (pinned) sx = ST_PINNED;
        else begin
          do_close = isopen;
          if (!(named_r[e_r] || nn_r) || !ok_r) sx = ST_FAIL;
          else begin do_open = 1'b1; walk_nxt = 1'b1; end
        end
      end
      OP_CLOSE: begin
        if (pinned) sx = ST_PINNED;
        else do_close = isopen;
      end
      OP_LOCK: begin
        if (pins_r[e_r] == PIN_MAX) sx = ST_FULL;
        else if (isopen) do_front = 1'b1;
        else if (!named_r[e_r] || !ok_r) sx = ST_FAIL;
        else begin do_open = 1'b1; walk_nxt = 1'b1; end
      end
      OP_UNLOCK: walk_nxt = pinned;
      default: ;
    endcase
  end
  assign st.need_walk = walk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= '0;
      named_r <= '0;
      for (int i = 0; i < ENTRIES; i++) pins_r[i] <= '0;
      cnt_r   <= '0;
      maxo_r  <= 5'd16;
    end else begin
      if (cfg_valid) maxo_r <= cfg_max_open;
      if (cmd.exec) begin
        if (op_t'(op_r) == OP_OPEN && !pinned && nn_r) named_r[e_r] <= 1'b1;
        if (op_t'(op_r) == OP_LOCK && sx == ST_OK) pins_r[e_r] <= pins_r[e_r] + 1'b1;
        if (op_t'(op_r) == OP_UNLOCK && pinned) pins_r[e_r] <= pins_r[e_r] - 1'b1;
        if (do_open) open_r[e_r] <= 1'b1;
        else if (do_close) open_r[e_r] <= 1'b0;
        // order update: remove (if open) then optionally push front
        if (do_close || do_front) begin
          for (int i = 1; i < ENTRIES; i++) begin
            if (do_open || do_front) begin
              if (IW'(i) <= fpos) ord_r[i] <= ord_r[i-1];
            end else if (IW'(i) > fpos) ord_r[i-1] <= ord_r[i];
          end
          if (do_open || do_front) ord_r[0] <= e_r;
          if (do_close && !do_open) cnt_r <= cnt_r - 1'b1;
        end else if (do_open) begin
          for (int i = 1; i < ENTRIES; i++) ord_r[i] <= ord_r[i-1];
          ord_r[0] <= e_r;
          cnt_r    <= cnt_r + 1'b1;
        end
      end
      if (cmd.walk && !st.walk_done) begin
        if (st.walk_hit) begin
          open_r[wentry] <= 1'b0;
          cnt_r <= cnt_r - 1'b1;
          for (int i = 0; i + 1 < ENTRIES; i++)
            if (CW'(i) >= posm1) ord_r[i] <= ord_r[i+1];
        end
      end
    end
  end

  // walk position and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op; e_r <= in_entry[IW-1:0]; nn_r <= in_new_name; ok_r <= in_open_ok;
    end
    if (cmd.exec) begin
      stat_r <= sx;
      pos_r  <= do_open ? ((do_close ? cnt_r : cnt_r + 1'b1)) : cnt_r;
    end
    if (cmd.walk && !st.walk_done) pos_r <= posm1;
    if (st.walk_hit && cmd.walk) begin
      evv_r <= 1'b1; ev_r <= wentry; last_r <= 1'b0;
    end else if (cmd.fin || (cmd.exec && !walk_nxt)) begin
      evv_r <= 1'b0; ev_r <= '0; last_r <= 1'b1;
    end
  end

  // final now_open/pins read live from state (stable while presenting)
  always_comb begin
    now_cur = open_r[e_r];
    pc_cur  = pins_r[e_r];
  end

  assign out_status        = evv_r ? 2'(ST_OK) : stat_r;
  assign out_evicted_valid = evv_r;
  assign out_evicted_entry = 4'(ev_r);
  assign out_now_open      = evv_r ? 1'b0 : now_cur;
  assign out_pin_count     = evv_r ? 8'd0 : 8'(pc_cur);
  assign out_is_last       = last_r && !evv_r;
endmodule

### sv/pinned_lru_open_slot_manager.sv
// A request is accepted in S_IDLE, applied in S_EXEC, and its final result is
// presented in S_FINAL. When an eviction walk runs, it examines one recency
// position per cycle, pausing in S_EVOUT while each eviction result is handed over.
// One request at a time: no new request is accepted until the final result
// of the current one has been taken.
// Reset (rst_n low, synchronous): all entries closed, unnamed, unpinned,
// open count zero, max_open 16. No clearing pass.
module pinned_lru_open_slot_manager
  import plosm_pkg::*;
#(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int PIN_BITS = PIN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [3:0] in_entry,
  input  logic       in_new_name,
  input  logic       in_open_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_evicted_valid,
  output logic [3:0] out_evicted_entry,
  output logic       out_now_open,
  output logic [7:0] out_pin_count,
  output logic       out_is_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);
  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  plosm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  plosm_dp #(.ENTRIES(ENTRIES), .PIN_BITS(PIN_BITS)) u_dp (
    .clk, .rst_n, .cmd, .st, .in_op, .in_entry, .in_new_name, .in_open_ok,
    .cfg_valid, .cfg_max_open(cfg_data), .out_status, .out_evicted_valid,
    .out_evicted_entry, .out_now_open, .out_pin_count, .out_is_last
  );
endmodule

### sv/plosm_checker.sv
module plosm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_evicted_valid,
  input logic out_is_last
);
  // a result is either an eviction or the final one
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_evicted_valid != out_is_last)) else $error("bad result kind");
  // no new request while results pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready during output");
  // after final result taken, block is idle again
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_is_last) |=> in_ready) else $error("not idle");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("valid dropped");
  // one request at a time
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after request");
endmodule

bind pinned_lru_open_slot_manager plosm_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_evicted_valid, .out_is_last
);

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import plosm_pkg::*;

  localparam int PIN_TOP   = 255;
  localparam int LIMIT_CYC = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_op = '0;
  logic [3:0] in_entry = '0;
  logic       in_new_name = 1'b0;
  logic       in_open_ok = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic       out_evicted_valid;
  logic [3:0] out_evicted_entry;
  logic       out_now_open;
  logic [7:0] out_pin_count;
  logic       out_is_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  pinned_lru_open_slot_manager u_dut (.*);

  always #1 clk = ~clk;

  typedef struct packed {
    logic [1:0] status;
    logic       ev_v;
    logic [3:0] ev_e;
    logic       now_open;
    logic [7:0] pins;
    logic       last;
  } slot_res_t;

  // slot model
  logic       m_open [16];
  logic       m_named [16];
  int         m_pins [16];
  logic [3:0] m_lru [16];
  int         m_cnt;
  int         m_max;
  slot_res_t  expected_q [$];

  int errors = 0;
  int cycles = 0;
  int stall_mode = 0;

  task automatic lru_remove_at(input int p);
    for (int i = p; i + 1 < m_cnt; i++) m_lru[i] = m_lru[i + 1];
    m_cnt--;
  endtask

  task automatic lru_drop(input logic [3:0] e);
    for (int i = 0; i < m_cnt; i++) begin
      if (m_lru[i] == e) begin
        lru_remove_at(i);
        return;
      end
    end
  endtask

  task automatic lru_front(input logic [3:0] e);
    if (m_cnt >= 16) return;
    for (int i = m_cnt; i > 0; i--) m_lru[i] = m_lru[i - 1];
    m_lru[0] = e;
    m_cnt++;
  endtask

  task automatic evict_oldest;
    int p;
    logic [3:0] e;
    p = m_cnt;
    while (m_cnt > m_max && p > 0) begin
      p--;
      e = m_lru[p];
      if (m_pins[e] == 0) begin
        m_open[e] = 1'b0;
        lru_remove_at(p);
        expected_q.push_back('{ST_OK, 1'b1, e, 1'b0, 8'd0, 1'b0});
      end
    end
  endtask

  task automatic try_open(input logic [3:0] e, input logic ok, output status_t st);
    st = ST_OK;
    if (!m_named[e]) st = ST_FAIL;
    else if (m_open[e]) st = ST_OK;
    else if (!ok) st = ST_FAIL;
    else begin
      m_open[e] = 1'b1;
      lru_front(e);
      evict_oldest();
    end
  endtask

  task automatic predict_request(input op_t op, input logic [3:0] e, input logic nn,
                                 input logic ok);
    status_t st;
    st = ST_OK;
    case (op)
      OP_OPEN: begin
        if (m_pins[e] > 0) st = ST_PINNED;
        else begin
          if (m_open[e]) begin
            m_open[e] = 1'b0;
            lru_drop(e);
          end
          if (nn) m_named[e] = 1'b1;
          try_open(e, ok, st);
        end
      end
      OP_CLOSE: begin
        if (m_pins[e] > 0) st = ST_PINNED;
        else if (m_open[e]) begin
          m_open[e] = 1'b0;
          lru_drop(e);
        end
      end
      OP_LOCK: begin
        if (m_pins[e] >= PIN_TOP) st = ST_FULL;
        else begin
          m_pins[e]++;
          if (!m_open[e]) begin
            try_open(e, ok, st);
            if (st != ST_OK) m_pins[e]--;
          end else if (m_cnt > 0 && m_lru[0] != e) begin
            lru_drop(e);
            lru_front(e);
          end
        end
      end
      default: begin
        if (m_pins[e] > 0) begin
          m_pins[e]--;
          evict_oldest();
        end
      end
    endcase
    expected_q.push_back('{st, 1'b0, 4'd0, m_open[e], m_pins[e][7:0], 1'b1});
  endtask

  // sender: random bursts and gaps
  int burst_left = 0;

  task automatic send_request(input op_t op, input logic [3:0] e, input logic nn,
                              input logic ok);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_entry <= e;
    in_new_name <= nn;
    in_open_ok <= ok;
    predict_request(op, e, nn, ok);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_max_open(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v[4:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_max = v;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    cycles++;
    if (cycles % 1500 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycles % 7) < 4;
    endcase
    if (cycles > LIMIT_CYC) begin
      $display("pinned_lru_open_slot_manager: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    slot_res_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_evicted_valid, out_evicted_entry, out_now_open,
              out_pin_count, out_is_last};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: exp st=%0d ev=%0d/%0d open=%0d pins=%0d last=%0d",
                     exp_r.status, exp_r.ev_v, exp_r.ev_e, exp_r.now_open, exp_r.pins,
                     exp_r.last,
                     ", got st=%0d ev=%0d/%0d open=%0d pins=%0d last=%0d",
                     got.status, got.ev_v, got.ev_e, got.now_open, got.pins, got.last);
        end
      end
    end
  end

  task automatic test_directed;
    send_request(OP_OPEN, 4'd0, 1'b0, 1'b1);   // no name
    send_request(OP_OPEN, 4'd0, 1'b1, 1'b0);   // name kept, open fails
    send_request(OP_OPEN, 4'd0, 1'b0, 1'b1);
    send_request(OP_OPEN, 4'd0, 1'b1, 1'b1);   // reopen
    send_request(OP_OPEN, 4'd15, 1'b1, 1'b1);
    send_request(OP_LOCK, 4'd0, 1'b0, 1'b0);   // lock open, move to front
    send_request(OP_OPEN, 4'd0, 1'b1, 1'b1);   // pinned
    send_request(OP_CLOSE, 4'd0, 1'b0, 1'b0);  // pinned
    send_request(OP_CLOSE, 4'd7, 1'b0, 1'b0);  // closed already
    send_request(OP_UNLOCK, 4'd7, 1'b0, 1'b0); // unpinned
    send_request(OP_LOCK, 4'd9, 1'b0, 1'b1);   // unnamed lock fails
    send_request(OP_UNLOCK, 4'd0, 1'b0, 1'b0);
    send_request(OP_CLOSE, 4'd15, 1'b0, 1'b0);
    for (int i = 0; i < PIN_TOP + 1; i++)      // reach full pin count
      send_request(OP_LOCK, 4'd15, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) send_request(OP_OPEN, i[3:0], 1'b1, 1'b1);
  endtask

  task automatic test_self_evict;
    write_max_open(0);
    send_request(OP_OPEN, 4'd3, 1'b1, 1'b1);
    send_request(OP_LOCK, 4'd4, 1'b1, 1'b1);
    send_request(OP_UNLOCK, 4'd4, 1'b0, 1'b0);
    send_request(OP_LOCK, 4'd5, 1'b1, 1'b1);
  endtask

  task automatic test_random(input int n, input int hot);
    op_t op;
    for (int i = 0; i < n; i++) begin
      op = op_t'($urandom_range(0, 3));
      send_request(op, 4'($urandom_range(0, hot)), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 5) != 0);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      m_open[i] = 1'b0;
      m_named[i] = 1'b0;
      m_pins[i] = 0;
      m_lru[i] = '0;
    end
    m_cnt = 0;
    m_max = 16;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_self_evict();
    write_max_open(4);
    test_random(30, 15);
    write_max_open(1);
    test_random(25, 7);
    write_max_open(31);
    test_random(15, 15);
    write_max_open(16);
    test_random(20, 15);
    write_max_open(8);
    test_random(20, 15);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("pinned_lru_open_slot_manager: match");
    end else begin
      $display("pinned_lru_open_slot_manager: mismatch");
    end
    $finish;
  end
endmodule
